/* rtl/core/h264nus_pkg.sv */
// shared types and constants for the h264 nal unit splitter
// no dependencies; used by every module of the block
`default_nettype none

package h264nus_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  START_TAIL = 8'h01;
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [4:0]  TYPE_MASK  = 5'h1f;
    localparam logic [4:0]  TYPE_IDR   = 5'h05;
    localparam logic [4:0]  TYPE_SPS   = 5'h07;
    localparam logic [4:0]  TYPE_PPS   = 5'h08;
    localparam logic [1:0]  HELD_MAX   = 2'd3;
    localparam logic [31:0] LEN_SAT    = 32'hffff_ffff;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // one entry per input byte that causes results
    typedef struct packed {
        logic [2:0]  zero_cnt;
        logic        byte_vld;
        logic [7:0]  data;
        logic        close;
        logic        header;
        logic [4:0]  nal_type;
        logic [31:0] length;
        logic [2:0]  res_cnt;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* rtl/core/h264nus_front.sv */
// front end: start code detection, unit state and per-byte result commands
// depends on h264nus_pkg
`default_nettype none

module h264nus_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [7:0]          data_byte,
    input  wire                 end_of_stream,
    input  wire                 cfg_we,
    input  wire                 cfg_wdata,
    input  h264nus_pkg::q_status_t q_status,
    output logic                push,
    output h264nus_pkg::cmd_t   push_cmd
);

    logic        drop_reg;
    logic [1:0]  held_reg, held_next;
    logic        in_unit_reg, in_unit_next;
    logic        awaiting_reg, awaiting_next;
    logic [4:0]  type_reg, type_next;
    logic [31:0] count_reg, count_next;

    logic        accept;
    logic        is_start;
    logic [2:0]  nz;
    logic        bv;
    logic [1:0]  held_after;
    logic [2:0]  ek;
    logic [32:0] count_sum;
    logic [31:0] count_new;
    logic        awaiting_new;
    logic [4:0]  type_new;
    logic [4:0]  res_type;
    logic        sup;
    logic        cl;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_start = (data_byte == h264nus_pkg::START_TAIL) && (held_reg >= 2'd2);

    always_comb
    begin
        nz         = 3'd0;
        bv         = 1'b0;
        held_after = held_reg;
        if (data_byte == h264nus_pkg::ZERO_BYTE)
        begin
            if (held_reg < h264nus_pkg::HELD_MAX)
                held_after = held_reg + 2'd1;
            else
                nz = 3'd1;
        end
        else if (is_start)
        begin
            held_after = 2'd0;
        end
        else
        begin
            nz         = {1'b0, held_reg};
            bv         = 1'b1;
            held_after = 2'd0;
        end
        // end of stream flushes the held zeros
        if (end_of_stream)
        begin
            nz         = nz + {1'b0, held_after};
            held_after = 2'd0;
        end
    end

    always_comb
    begin
        ek           = in_unit_reg ? (nz + {2'b00, bv}) : 3'd0;
        count_sum    = {1'b0, count_reg} + {30'd0, ek};
        count_new    = count_sum[32] ? h264nus_pkg::LEN_SAT : count_sum[31:0];
        awaiting_new = awaiting_reg && (ek == 3'd0);
        if (awaiting_reg && (ek != 3'd0))
            type_new = (nz != 3'd0) ? 5'd0 : (data_byte[4:0] & h264nus_pkg::TYPE_MASK);
        else
            type_new = type_reg;

        res_type = is_start ? type_reg : type_new;
        sup      = drop_reg && ((res_type == h264nus_pkg::TYPE_SPS) ||
                                (res_type == h264nus_pkg::TYPE_PPS));
        if (is_start)
            cl = in_unit_reg && !awaiting_reg;
        else
            cl = end_of_stream && in_unit_reg && !awaiting_new;

        push_cmd          = '0;
        push_cmd.data     = data_byte;
        push_cmd.nal_type = res_type;
        push_cmd.length   = is_start ? count_reg : count_new;
        push_cmd.close    = cl && !sup;
        if (in_unit_reg && !sup && !is_start)
        begin
            push_cmd.zero_cnt = nz;
            push_cmd.byte_vld = bv;
            push_cmd.header   = awaiting_reg && (ek != 3'd0);
        end
        push_cmd.res_cnt = push_cmd.zero_cnt + {2'b00, push_cmd.byte_vld}
                         + {2'b00, push_cmd.close};
        push = accept && (push_cmd.res_cnt != 3'd0);
    end

    always_comb
    begin
        held_next     = held_reg;
        in_unit_next  = in_unit_reg;
        awaiting_next = awaiting_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        if (accept)
        begin
            if (is_start)
            begin
                held_next     = 2'd0;
                in_unit_next  = 1'b1;
                awaiting_next = 1'b1;
                type_next     = 5'd0;
                count_next    = 32'd0;
            end
            else
            begin
                held_next     = held_after;
                awaiting_next = awaiting_new;
                type_next     = type_new;
                count_next    = count_new;
            end
            if (end_of_stream)
            begin
                held_next     = 2'd0;
                in_unit_next  = 1'b0;
                awaiting_next = 1'b0;
                type_next     = 5'd0;
                count_next    = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg     <= 1'b1;
            held_reg     <= 2'd0;
            in_unit_reg  <= 1'b0;
            awaiting_reg <= 1'b0;
            type_reg     <= 5'd0;
            count_reg    <= 32'd0;
        end
        else
        begin
            if (cfg_we)
                drop_reg <= cfg_wdata;
            held_reg     <= held_next;
            in_unit_reg  <= in_unit_next;
            awaiting_reg <= awaiting_next;
            type_reg     <= type_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/h264nus_queue.sv */
// short command queue between front end and back end
// depends on h264nus_pkg
`default_nettype none

module h264nus_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  h264nus_pkg::cmd_t      push_cmd,
    input  wire                    pop,
    output h264nus_pkg::cmd_t      head_cmd,
    output h264nus_pkg::q_status_t q_status
);

    localparam int AW = h264nus_pkg::QUEUE_AW;

    h264nus_pkg::cmd_t entry_reg [h264nus_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign q_status.full  = (fill_reg == (AW+1)'(h264nus_pkg::QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (AW+1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/h264nus_back.sv */
// back end: expands each command into result transfers through an output register
// depends on h264nus_pkg
`default_nettype none

module h264nus_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  h264nus_pkg::cmd_t      head_cmd,
    input  h264nus_pkg::q_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic                   item_kind,
    output logic [7:0]             payload_byte,
    output logic                   unit_first,
    output logic [4:0]             unit_type,
    output logic                   key_frame,
    output logic [31:0]            unit_length,
    output logic                   run_last
);

    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic        first_reg, first_next;
    logic [4:0]  type_reg, type_next;
    logic        key_reg, key_next;
    logic [31:0] len_reg, len_next;
    logic        last_reg, last_next;

    logic advance;
    logic zero_sel;
    logic byte_sel;
    logic is_last;

    always_comb
    begin
        advance  = !q_status.empty && (!out_valid_reg || out_ready);
        zero_sel = step_reg < head_cmd.zero_cnt;
        byte_sel = !zero_sel && head_cmd.byte_vld && (step_reg == head_cmd.zero_cnt);
        is_last  = (step_reg + 3'd1) == head_cmd.res_cnt;
        pop      = advance && is_last;

        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        first_next     = first_reg;
        type_next      = type_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        if (advance)
        begin
            step_next      = is_last ? 3'd0 : step_reg + 3'd1;
            out_valid_next = 1'b1;
            type_next      = head_cmd.nal_type;
            key_next       = (head_cmd.nal_type == h264nus_pkg::TYPE_IDR);
            last_next      = is_last;
            if (zero_sel || byte_sel)
            begin
                kind_next  = h264nus_pkg::KIND_PAYLOAD;
                byte_next  = byte_sel ? head_cmd.data : h264nus_pkg::ZERO_BYTE;
                first_next = head_cmd.header && (step_reg == 3'd0);
                len_next   = 32'd0;
            end
            else
            begin
                kind_next  = h264nus_pkg::KIND_END;
                byte_next  = h264nus_pkg::ZERO_BYTE;
                first_next = 1'b0;
                len_next   = head_cmd.length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        first_reg <= first_next;
        type_reg  <= type_next;
        key_reg   <= key_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign item_kind    = kind_reg;
    assign payload_byte = byte_reg;
    assign unit_first   = first_reg;
    assign unit_type    = type_reg;
    assign key_frame    = key_reg;
    assign unit_length  = len_reg;
    assign run_last     = last_reg;

endmodule

`default_nettype wire

/* rtl/core/h264_nal_unit_splitter.sv */
// path: a byte's command is queued, then each result goes into the output register
// throughput: one byte per cycle in while the queue has room, one result per cycle
//   out if out_ready is high; a four-entry queue absorbs multi-result bytes
// reset: asynchronous, clears unit state and queue; the drop flag resets to 1
// top level of the h264 nal unit splitter; depends on h264nus_pkg and its submodules
`default_nettype none

module h264_nal_unit_splitter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  data_byte,
    input  wire         end_of_stream,
    input  wire         cfg_we,
    input  wire         cfg_wdata,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        item_kind,
    output logic [7:0]  payload_byte,
    output logic        unit_first,
    output logic [4:0]  unit_type,
    output logic        key_frame,
    output logic [31:0] unit_length,
    output logic        run_last
);

    h264nus_pkg::q_status_t q_status;
    h264nus_pkg::cmd_t      push_cmd;
    h264nus_pkg::cmd_t      head_cmd;
    logic                   push;
    logic                   pop;

    h264nus_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    h264nus_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    h264nus_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .item_kind    (item_kind),
        .payload_byte (payload_byte),
        .unit_first   (unit_first),
        .unit_type    (unit_type),
        .key_frame    (key_frame),
        .unit_length  (unit_length),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

/* rtl/core/h264nus_checker.sv */
// port-level checks for the h264 nal unit splitter, bound to the top level
// depends on h264nus_pkg
`default_nettype none

module h264nus_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire        item_kind,
    input wire [7:0]  payload_byte,
    input wire        unit_first,
    input wire [4:0]  unit_type,
    input wire        key_frame,
    input wire [31:0] unit_length,
    input wire        run_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte)
            && $stable(unit_length) && $stable(item_kind) && $stable(run_last))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_frame == (unit_type == h264nus_pkg::TYPE_IDR))
        else $error("key frame flag does not match unit type");

    // end items carry a non-empty length and no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == h264nus_pkg::KIND_END) |->
            (unit_length != 32'd0) && (payload_byte == 8'd0) && !unit_first)
        else $error("malformed end of unit transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == h264nus_pkg::KIND_PAYLOAD) |-> unit_length == 32'd0)
        else $error("payload transfer with nonzero length");

endmodule

bind h264_nal_unit_splitter h264nus_checker u_checker (.*);

`default_nettype wire

/* tb/sv/nal_split_checker.sv */
// checker for the h264 nal unit splitter: watches both channels and the config port,
// predicts every result from the accepted bytes and compares in order
// depends on h264nus_pkg for codes and constants
module nal_split_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        item_kind,
    input  logic [7:0]  payload_byte,
    input  logic        unit_first,
    input  logic [4:0]  unit_type,
    input  logic        key_frame,
    input  logic [31:0] unit_length,
    input  logic        run_last,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic        first;
        logic [4:0]  ntype;
        logic        key;
        logic [31:0] len;
        logic        last;
    } nal_item_t;

    logic        drop_ps;
    logic [1:0]  held_zeros;
    logic        in_unit;
    logic        want_header;
    logic [4:0]  cur_type;
    logic [31:0] unit_bytes;

    nal_item_t   step_items[$];
    nal_item_t   expected_items[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (fail_count < 50)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic is_dropped();
        return drop_ps && (cur_type == h264nus_pkg::TYPE_SPS ||
                           cur_type == h264nus_pkg::TYPE_PPS);
    endfunction

    task automatic push_result(logic kind, logic [7:0] b, logic first, logic [31:0] len);
        nal_item_t it;
        if (step_items.size() >= 5)
            return;
        it.kind  = kind;
        it.pbyte = b;
        it.first = first;
        it.ntype = cur_type;
        it.key   = (cur_type == h264nus_pkg::TYPE_IDR);
        it.len   = len;
        it.last  = 1'b0;
        step_items.push_back(it);
    endtask

    task automatic emit_byte(logic [7:0] b);
        logic first;
        first = 1'b0;
        if (!in_unit)
            return;
        if (want_header)
        begin
            cur_type    = b[4:0] & h264nus_pkg::TYPE_MASK;
            want_header = 1'b0;
            first       = 1'b1;
        end
        if (unit_bytes != h264nus_pkg::LEN_SAT)
            unit_bytes++;
        if (!is_dropped())
            push_result(h264nus_pkg::KIND_PAYLOAD, b, first, '0);
    endtask

    task automatic close_unit();
        if (in_unit && !want_header && !is_dropped())
            push_result(h264nus_pkg::KIND_END, h264nus_pkg::ZERO_BYTE, 1'b0, unit_bytes);
    endtask

    task automatic flush_zeros();
        while (held_zeros > 0)
        begin
            emit_byte(h264nus_pkg::ZERO_BYTE);
            held_zeros--;
        end
    endtask

    task automatic clear_unit();
        held_zeros  = '0;
        in_unit     = 1'b0;
        want_header = 1'b0;
        cur_type    = '0;
        unit_bytes  = '0;
    endtask

    task automatic predict_byte(logic [7:0] b, logic eos);
        nal_item_t it;
        step_items.delete();
        if (b == h264nus_pkg::ZERO_BYTE)
        begin
            if (held_zeros < h264nus_pkg::HELD_MAX)
                held_zeros++;
            else
                emit_byte(h264nus_pkg::ZERO_BYTE);
        end
        else if (b == h264nus_pkg::START_TAIL && held_zeros >= 2)
        begin
            close_unit();
            in_unit     = 1'b1;
            want_header = 1'b1;
            cur_type    = '0;
            unit_bytes  = '0;
            held_zeros  = '0;
        end
        else
        begin
            flush_zeros();
            emit_byte(b);
        end
        if (eos)
        begin
            flush_zeros();
            close_unit();
            clear_unit();
        end
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].last = 1'b1;
        foreach (step_items[i])
        begin
            it = step_items[i];
            expected_items.push_back(it);
        end
    endtask

    task automatic check_result();
        nal_item_t want;
        if (expected_items.size() == 0)
        begin
            report_mismatch("result transfer with nothing expected", payload_byte, 0);
            return;
        end
        want = expected_items.pop_front();
        if (item_kind != want.kind)
            report_mismatch("item_kind", item_kind, want.kind);
        if (payload_byte != want.pbyte)
            report_mismatch("payload_byte", payload_byte, want.pbyte);
        if (unit_first != want.first)
            report_mismatch("unit_first", unit_first, want.first);
        if (unit_type != want.ntype)
            report_mismatch("unit_type", unit_type, want.ntype);
        if (key_frame != want.key)
            report_mismatch("key_frame", key_frame, want.key);
        if (unit_length != want.len)
            report_mismatch("unit_length", unit_length, want.len);
        if (run_last != want.last)
            report_mismatch("run_last", run_last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_ps = 1'b1;
            clear_unit();
            expected_items.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_byte(data_byte, end_of_stream);
            if (cfg_we)
                drop_ps = cfg_wdata;
            pending = expected_items.size();
        end
    end

endmodule

/* tb/sv/tb_h264_nal_unit_splitter.sv */
// top of the h264 nal unit splitter testbench: clock, reset, byte stream stimulus,
// receiver stalls and the verdict; checking lives in nal_split_checker
// depends on h264nus_pkg, nal_split_checker and the block itself
module tb_h264_nal_unit_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    // bit 8 is end_of_stream
    localparam logic [8:0] DIRECTED [23] = '{
        9'h0ff, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001,
        9'h065, 9'h000, 9'h000, 9'h000, 9'h000, 9'h07f,
        9'h000, 9'h000, 9'h001,
        9'h067, 9'h000, 9'h000, 9'h001,
        9'h000, 9'h000, 9'h001,
        9'h100
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        out_valid;
    logic        out_ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic        unit_first;
    logic [4:0]  unit_type;
    logic        key_frame;
    logic [31:0] unit_length;
    logic        run_last;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int          bytes_sent;
    int          burst_left;
    int          rx_cycle;
    int          rx_mode;
    logic [7:0]  rx_mask;
    logic        stall_armed;
    logic        long_stall;

    h264_nal_unit_splitter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .payload_byte  (payload_byte),
        .unit_first    (unit_first),
        .unit_type     (unit_type),
        .key_frame     (key_frame),
        .unit_length   (unit_length),
        .run_last      (run_last)
    );

    nal_split_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .payload_byte  (payload_byte),
        .unit_first    (unit_first),
        .unit_type     (unit_type),
        .key_frame     (key_frame),
        .unit_length   (unit_length),
        .run_last      (run_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: out_ready follows a stall pattern that is chosen anew at random
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mask = 8'($urandom) | 8'h01;
        end
        if (long_stall)
            out_ready = 1'b0;
        else
            case (rx_mode)
                0:       out_ready = 1'b1;
                1:       out_ready = ($urandom_range(0, 3) != 0);
                2:       out_ready = rx_mask[rx_cycle % 8];
                default: out_ready = ($urandom_range(0, 3) == 0);
            endcase
    end

    // one long receiver hold-off while bytes keep coming
    initial
    begin
        wait (stall_armed);
        repeat ($urandom_range(30, 80)) @(negedge clk);
        long_stall = 1'b1;
        repeat (400) @(negedge clk);
        long_stall = 1'b0;
    end

    function automatic logic pick_eos();
        return ($urandom_range(0, 49) == 0);
    endfunction

    task automatic send_byte(logic [7:0] b, logic eos);
        in_valid      = 1'b1;
        data_byte     = b;
        end_of_stream = eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    task automatic set_drop(logic v);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic drain_block();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic send_unit();
        int          zeros;
        int          plen;
        int          r;
        logic [7:0]  b;
        logic [4:0]  t;
        zeros = ($urandom_range(0, 3) == 0) ? 3 : 2;
        if ($urandom_range(0, 9) == 0)
            zeros += $urandom_range(1, 3);
        repeat (zeros) send_byte(h264nus_pkg::ZERO_BYTE, pick_eos());
        send_byte(h264nus_pkg::START_TAIL, pick_eos());
        case ($urandom_range(0, 5))
            0:       t = h264nus_pkg::TYPE_IDR;
            1:       t = h264nus_pkg::TYPE_SPS;
            2:       t = h264nus_pkg::TYPE_PPS;
            3:       t = 5'd1;
            default: t = 5'($urandom);
        endcase
        b = 8'($urandom);
        b = {b[7:5], t};
        // an empty unit now and then
        if ($urandom_range(0, 15) == 0)
            return;
        send_byte(b, pick_eos());
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
        repeat (plen)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                b = h264nus_pkg::ZERO_BYTE;
            else if (r == 3)
                b = h264nus_pkg::START_TAIL;
            else
                b = 8'($urandom);
            send_byte(b, pick_eos());
        end
    endtask

    task automatic random_stream(int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom), pick_eos());
            else
                send_unit();
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        out_ready     = 1'b0;
        cycle_count   = 0;
        bytes_sent    = 0;
        burst_left    = 0;
        rx_cycle      = 0;
        rx_mode       = 0;
        rx_mask       = 8'hff;
        stall_armed   = 1'b0;
        long_stall    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_drop(1'b1);
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        drain_block();

        set_drop(1'b0);
        stall_armed = 1'b1;
        random_stream(205);
        drain_block();

        set_drop(1'b1);
        random_stream(200);
        send_byte(8'h42, 1'b1);

        drain_block();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
